/* design/sap_pkg.sv */
// Shared constants and types for the sphere/box overlap push block.
package sap_pkg;

  localparam int COORD_WIDTH = 32;

  typedef struct packed {
    logic       hit;
    logic       use_v;
    logic [2:0] neg;
  } sap_ctl_t;

endpackage

/* design/sap_if.sv */
// Valid/ready channel interfaces for the input and result words.
interface sap_in_if #(parameter int W = sap_pkg::COORD_WIDTH) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sphere_x;
  logic signed [W-1:0] sphere_y;
  logic signed [W-1:0] sphere_z;
  logic        [W-2:0] sphere_radius;
  logic signed [W-1:0] box_min_x;
  logic signed [W-1:0] box_min_y;
  logic signed [W-1:0] box_min_z;
  logic signed [W-1:0] box_max_x;
  logic signed [W-1:0] box_max_y;
  logic signed [W-1:0] box_max_z;

  modport source (
    output valid, sphere_x, sphere_y, sphere_z, sphere_radius,
           box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    input  ready
  );
  modport sink (
    input  valid, sphere_x, sphere_y, sphere_z, sphere_radius,
           box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    output ready
  );
endinterface

interface sap_out_if #(parameter int W = sap_pkg::COORD_WIDTH) ();
  logic                valid;
  logic                ready;
  logic                hit;
  logic signed [W-1:0] push_x;
  logic signed [W-1:0] push_y;
  logic signed [W-1:0] push_z;

  modport source (output valid, hit, push_x, push_y, push_z, input ready);
  modport sink   (input valid, hit, push_x, push_y, push_z, output ready);
endinterface

/* design/sap_front.sv */
// Front stages: clamp, offset vectors, squares, sums and hit test.
module sap_front #(
  parameter int W = sap_pkg::COORD_WIDTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                vld_i,
  input  logic signed [W-1:0] pos_i [3],
  input  logic signed [W-1:0] lo_i  [3],
  input  logic signed [W-1:0] hi_i  [3],
  input  logic        [W-2:0] rad_i,
  output logic                vld_o,
  output sap_pkg::sap_ctl_t   ctl_o,
  output logic      [2*W+3:0] t_o,
  output logic        [W-2:0] r_o,
  output logic        [W+1:0] u_o [3]
);

  localparam int VW = W + 1;
  localparam int CW = W + 3;
  localparam int SW = 2 * W;
  localparam int TW = 2 * W + 4;
  localparam int UW = W + 2;

  // stage 1
  logic signed [W-1:0]  cl      [3];
  logic signed [VW-1:0] v1_nxt  [3];
  logic signed [CW-1:0] c1_nxt  [3];
  logic signed [VW-1:0] v1_r    [3];
  logic signed [CW-1:0] c1_r    [3];
  logic        [W-2:0]  r1_r;
  logic                 vld1_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (pos_i[i] < lo_i[i]) begin
        cl[i] = lo_i[i];
      end else if (hi_i[i] < pos_i[i]) begin
        cl[i] = hi_i[i];
      end else begin
        cl[i] = pos_i[i];
      end
      v1_nxt[i] = VW'(pos_i[i]) - VW'(cl[i]);
      c1_nxt[i] = (CW'(pos_i[i]) <<< 1) - CW'(lo_i[i]) - CW'(hi_i[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else if (en) begin
      vld1_r <= vld_i;
    end
    if (en) begin
      v1_r <= v1_nxt;
      c1_r <= c1_nxt;
      r1_r <= rad_i;
    end
  end

  // stage 2
  logic [VW-1:0]    mv      [3];
  logic [CW-1:0]    ca      [3];
  logic [W-2:0]     mvs_nxt [3];
  logic [UW-1:0]    mc_nxt  [3];
  logic [2*W-3:0]   sqv_nxt [3];
  logic [TW-1:0]    sqc_nxt [3];
  logic [2*W-3:0]   rr_nxt;
  logic             far_nxt;
  logic [W-2:0]     mvs2_r  [3];
  logic [UW-1:0]    mc2_r   [3];
  logic [2*W-3:0]   sqv2_r  [3];
  logic [TW-1:0]    sqc2_r  [3];
  logic [2*W-3:0]   rr2_r;
  logic             far2_r;
  logic [2:0]       negv2_r;
  logic [2:0]       negc2_r;
  logic [W-2:0]     r2_r;
  logic             vld2_r;

  always_comb begin
    far_nxt = 1'b0;
    for (int i = 0; i < 3; i++) begin
      mv[i]      = v1_r[i][VW-1] ? VW'(-v1_r[i]) : VW'(v1_r[i]);
      ca[i]      = c1_r[i][CW-1] ? CW'(-c1_r[i]) : CW'(c1_r[i]);
      far_nxt    = far_nxt | mv[i][W] | mv[i][W-1];
      mvs_nxt[i] = mv[i][W-2:0];
      mc_nxt[i]  = ca[i][UW-1:0];
      sqv_nxt[i] = mvs_nxt[i] * mvs_nxt[i];
      sqc_nxt[i] = mc_nxt[i] * mc_nxt[i];
    end
    rr_nxt = r1_r * r1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else if (en) begin
      vld2_r <= vld1_r;
    end
    if (en) begin
      mvs2_r <= mvs_nxt;
      mc2_r  <= mc_nxt;
      sqv2_r <= sqv_nxt;
      sqc2_r <= sqc_nxt;
      rr2_r  <= rr_nxt;
      far2_r <= far_nxt;
      for (int i = 0; i < 3; i++) begin
        negv2_r[i] <= v1_r[i][VW-1];
        negc2_r[i] <= c1_r[i][CW-1];
      end
      r2_r <= r1_r;
    end
  end

  // stage 3
  logic [SW-1:0]     s_sum;
  logic [TW-1:0]     sc_sum;
  sap_pkg::sap_ctl_t ctl_nxt;
  logic [TW-1:0]     t_nxt;
  logic [UW-1:0]     u_nxt [3];
  sap_pkg::sap_ctl_t ctl3_r;
  logic [TW-1:0]     t3_r;
  logic [UW-1:0]     u3_r  [3];
  logic [W-2:0]      r3_r;
  logic              vld3_r;

  always_comb begin
    s_sum  = SW'(sqv2_r[0]) + SW'(sqv2_r[1]) + SW'(sqv2_r[2]);
    sc_sum = sqc2_r[0] + sqc2_r[1] + sqc2_r[2];
    ctl_nxt.hit   = !far2_r && (s_sum < SW'(rr2_r));
    ctl_nxt.use_v = (s_sum != '0);
    ctl_nxt.neg   = ctl_nxt.use_v ? negv2_r : negc2_r;
    t_nxt = ctl_nxt.use_v ? TW'(s_sum) : sc_sum;
    for (int i = 0; i < 3; i++) begin
      u_nxt[i] = ctl_nxt.use_v ? UW'(mvs2_r[i]) : mc2_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
    end else if (en) begin
      vld3_r <= vld2_r;
    end
    if (en) begin
      ctl3_r <= ctl_nxt;
      t3_r   <= t_nxt;
      u3_r   <= u_nxt;
      r3_r   <= r2_r;
    end
  end

  assign vld_o = vld3_r;
  assign ctl_o = ctl3_r;
  assign t_o   = t3_r;
  assign r_o   = r3_r;
  assign u_o   = u3_r;

endmodule

/* design/sap_sqrt.sv */
// Pipelined integer square root, one root bit per stage.
module sap_sqrt #(
  parameter int W   = sap_pkg::COORD_WIDTH,
  parameter int SDW = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               vld_i,
  input  logic [2*W+3:0]     t_i,
  input  logic [SDW-1:0]     side_i,
  output logic               vld_o,
  output logic [W+1:0]       root_o,
  output logic [SDW-1:0]     side_o
);

  localparam int RW = W + 2;
  localparam int TW = 2 * RW;
  localparam int MW = RW + 2;

  logic           vld_r  [RW];
  logic [MW-1:0]  rem_r  [RW];
  logic [RW-1:0]  root_r [RW];
  logic [TW-1:0]  t_r    [RW];
  logic [SDW-1:0] side_r [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic           pv;
    logic [MW-1:0]  prem;
    logic [RW-1:0]  proot;
    logic [TW-1:0]  pt;
    logic [SDW-1:0] pside;
    logic [MW-1:0]  rem_sh;
    logic [MW-1:0]  trial;
    logic           ge;

    if (k == 0) begin : g_first
      assign pv    = vld_i;
      assign prem  = '0;
      assign proot = '0;
      assign pt    = t_i;
      assign pside = side_i;
    end else begin : g_next
      assign pv    = vld_r[k-1];
      assign prem  = rem_r[k-1];
      assign proot = root_r[k-1];
      assign pt    = t_r[k-1];
      assign pside = side_r[k-1];
    end

    assign rem_sh = {prem[MW-3:0], pt[TW-1:TW-2]};
    assign trial  = {proot, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= pv;
      end
      if (en) begin
        rem_r[k]  <= ge ? (rem_sh - trial) : rem_sh;
        root_r[k] <= {proot[RW-2:0], ge};
        t_r[k]    <= {pt[TW-3:0], 2'b00};
        side_r[k] <= pside;
      end
    end
  end

  assign vld_o  = vld_r[RW-1];
  assign root_o = root_r[RW-1];
  assign side_o = side_r[RW-1];

endmodule

/* design/sap_scale.sv */
// Push scaling: penetration, products, pipelined three-lane divide, output word.
module sap_scale #(
  parameter int W = sap_pkg::COORD_WIDTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                vld_i,
  input  sap_pkg::sap_ctl_t   ctl_i,
  input  logic        [W-2:0] r_i,
  input  logic        [W+1:0] d_i,
  input  logic        [W+1:0] u_i [3],
  output logic                vld_o,
  output logic                hit_o,
  output logic signed [W-1:0] push_o [3]
);

  localparam int UW = W + 2;
  localparam int NW = 2 * W + 1;
  localparam int Q  = W - 1;

  // penetration depth
  logic              vld1_r;
  sap_pkg::sap_ctl_t ctl1_r;
  logic [W-2:0]      p1_r;
  logic              mid1_r;
  logic [UW-1:0]     d1_r;
  logic [UW-1:0]     u1_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else if (en) begin
      vld1_r <= vld_i;
    end
    if (en) begin
      ctl1_r <= ctl_i;
      p1_r   <= ctl_i.use_v ? (r_i - d_i[W-2:0]) : r_i;
      mid1_r <= (d_i == '0);
      d1_r   <= d_i;
      u1_r   <= u_i;
    end
  end

  // products
  logic              vld2_r;
  sap_pkg::sap_ctl_t ctl2_r;
  logic [W-2:0]      p2_r;
  logic              mid2_r;
  logic [UW-1:0]     d2_r;
  logic [NW-1:0]     n2_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else if (en) begin
      vld2_r <= vld1_r;
    end
    if (en) begin
      ctl2_r <= ctl1_r;
      p2_r   <= p1_r;
      mid2_r <= mid1_r;
      d2_r   <= d1_r;
      for (int i = 0; i < 3; i++) begin
        n2_r[i] <= NW'(u1_r[i]) * NW'(p1_r);
      end
    end
  end

  // restoring divide, one quotient bit per stage
  logic              dv_r   [Q];
  sap_pkg::sap_ctl_t dctl_r [Q];
  logic [W-2:0]      dp_r   [Q];
  logic              dmid_r [Q];
  logic [UW-1:0]     dd_r   [Q];
  logic [NW-1:0]     rem_r  [Q][3];
  logic [Q-1:0]      q_r    [Q][3];

  for (genvar j = 0; j < Q; j++) begin : g_div
    localparam int SH = Q - 1 - j;
    logic              pv;
    sap_pkg::sap_ctl_t pctl;
    logic [W-2:0]      pp;
    logic              pmid;
    logic [UW-1:0]     pd;
    logic [NW-1:0]     prem [3];
    logic [Q-1:0]      pq   [3];
    logic [NW-1:0]     dsh;
    logic [NW-1:0]     rem_nxt [3];
    logic [Q-1:0]      q_nxt   [3];

    if (j == 0) begin : g_first
      assign pv   = vld2_r;
      assign pctl = ctl2_r;
      assign pp   = p2_r;
      assign pmid = mid2_r;
      assign pd   = d2_r;
      assign prem = n2_r;
      assign pq   = '{default: '0};
    end else begin : g_next
      assign pv   = dv_r[j-1];
      assign pctl = dctl_r[j-1];
      assign pp   = dp_r[j-1];
      assign pmid = dmid_r[j-1];
      assign pd   = dd_r[j-1];
      assign prem = rem_r[j-1];
      assign pq   = q_r[j-1];
    end

    assign dsh = NW'(pd) << SH;

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        if (prem[l] >= dsh) begin
          rem_nxt[l] = prem[l] - dsh;
          q_nxt[l]   = {pq[l][Q-2:0], 1'b1};
        end else begin
          rem_nxt[l] = prem[l];
          q_nxt[l]   = {pq[l][Q-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[j] <= 1'b0;
      end else if (en) begin
        dv_r[j] <= pv;
      end
      if (en) begin
        dctl_r[j] <= pctl;
        dp_r[j]   <= pp;
        dmid_r[j] <= pmid;
        dd_r[j]   <= pd;
        rem_r[j]  <= rem_nxt;
        q_r[j]    <= q_nxt;
      end
    end
  end

  // output word
  sap_pkg::sap_ctl_t   lctl;
  logic                vld_r;
  logic                hit_r;
  logic signed [W-1:0] push_nxt [3];
  logic signed [W-1:0] push_r   [3];

  assign lctl = dctl_r[Q-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (!lctl.hit) begin
        push_nxt[i] = '0;
      end else if (dmid_r[Q-1]) begin
        push_nxt[i] = (i == 1) ? {1'b0, dp_r[Q-1]} : '0;
      end else if (lctl.neg[i]) begin
        push_nxt[i] = -{1'b0, q_r[Q-1][i]};
      end else begin
        push_nxt[i] = {1'b0, q_r[Q-1][i]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= dv_r[Q-1];
    end
    if (en) begin
      hit_r  <= lctl.hit;
      push_r <= push_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign hit_o  = hit_r;
  assign push_o = push_r;

endmodule

/* design/sphere_aabb_overlap_push.sv */
// Top level: sphere versus axis-aligned box overlap with push vector.
//
//   channel   dir  handshake        word
//   in_chan   in   valid/ready      sphere center, radius, box min/max corners
//   out_chan  out  valid/ready      hit, push_x, push_y, push_z
//
// One word enters per cycle unless out_chan stalls; the pipe has three front
// stages, COORD_WIDTH + 2 square root stages (one root bit each) and
// COORD_WIDTH + 2 scale stages (two, then one quotient bit each, then output).
// Reset clears the stage valid bits only; no clearing pass.
// A taken-less output word freezes the whole pipe; in_chan.ready drops with it.
module sphere_aabb_overlap_push #(
  parameter int COORD_WIDTH = sap_pkg::COORD_WIDTH
) (
  input logic         clk,
  input logic         rst_n,
  sap_in_if.sink      in_chan,
  sap_out_if.source   out_chan
);

  localparam int W   = COORD_WIDTH;
  localparam int UW  = W + 2;
  localparam int CTW = $bits(sap_pkg::sap_ctl_t);
  localparam int SDW = CTW + (W - 1) + 3 * UW;

  logic en;
  assign en = !out_chan.valid || out_chan.ready;
  assign in_chan.ready = en;

  logic signed [W-1:0] pos [3];
  logic signed [W-1:0] lo  [3];
  logic signed [W-1:0] hi  [3];

  assign pos = '{in_chan.sphere_x, in_chan.sphere_y, in_chan.sphere_z};
  assign lo  = '{in_chan.box_min_x, in_chan.box_min_y, in_chan.box_min_z};
  assign hi  = '{in_chan.box_max_x, in_chan.box_max_y, in_chan.box_max_z};

  logic              f_vld;
  sap_pkg::sap_ctl_t f_ctl;
  logic [2*W+3:0]    f_t;
  logic [W-2:0]      f_r;
  logic [UW-1:0]     f_u [3];

  sap_front #(.W(W)) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (in_chan.valid),
    .pos_i (pos),
    .lo_i  (lo),
    .hi_i  (hi),
    .rad_i (in_chan.sphere_radius),
    .vld_o (f_vld),
    .ctl_o (f_ctl),
    .t_o   (f_t),
    .r_o   (f_r),
    .u_o   (f_u)
  );

  logic [SDW-1:0]    side_in;
  logic [SDW-1:0]    side_out;
  logic              s_vld;
  logic [UW-1:0]     s_root;
  sap_pkg::sap_ctl_t s_ctl;
  logic [W-2:0]      s_r;
  logic [UW-1:0]     s_u [3];

  assign side_in = {f_ctl, f_r, f_u[0], f_u[1], f_u[2]};

  sap_sqrt #(.W(W), .SDW(SDW)) u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (f_vld),
    .t_i    (f_t),
    .side_i (side_in),
    .vld_o  (s_vld),
    .root_o (s_root),
    .side_o (side_out)
  );

  assign {s_ctl, s_r, s_u[0], s_u[1], s_u[2]} = side_out;

  logic                o_hit;
  logic signed [W-1:0] o_push [3];

  sap_scale #(.W(W)) u_scale (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (s_vld),
    .ctl_i  (s_ctl),
    .r_i    (s_r),
    .d_i    (s_root),
    .u_i    (s_u),
    .vld_o  (out_chan.valid),
    .hit_o  (o_hit),
    .push_o (o_push)
  );

  assign out_chan.hit    = o_hit;
  assign out_chan.push_x = o_push[0];
  assign out_chan.push_y = o_push[1];
  assign out_chan.push_z = o_push[2];

endmodule

/* bench/sphere_aabb_overlap_push_tb.sv */
// Testbench for the sphere versus axis-aligned box overlap push block.
module sphere_aabb_overlap_push_tb;

  localparam int LATENCY = 2 * sap_pkg::COORD_WIDTH + 7;
  localparam int N_ITEMS = 900;
  localparam int QUIET_FROM = 760;
  localparam int HOLD_AT = 300;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic signed [31:0] cx, cy, cz;
    logic [30:0]        radius;
    logic signed [31:0] lox, loy, loz, hix, hiy, hiz;
  } overlap_query_t;

  typedef struct {
    logic               hit;
    logic signed [31:0] px, py, pz;
  } push_result_t;

  class push_scoreboard;
    push_result_t pending_q[$];
    int           failures;
    int           n_checked;
    int           n_hits;
    int           n_inside;
    int           n_midpoint;

    function automatic logic [63:0] isqrt(logic [127:0] s);
      logic [63:0]  res;
      logic [63:0]  t;
      res = '0;
      for (int b = 63; b >= 0; b--) begin
        t = res | (64'd1 << b);
        if ({64'd0, t} * {64'd0, t} <= s) res = t;
      end
      return res;
    endfunction

    function automatic logic [127:0] sumsq(longint a, longint b, longint c);
      logic [127:0] ma, mb, mc;
      ma = 128'((a < 0) ? -a : a);
      mb = 128'((b < 0) ? -b : b);
      mc = 128'((c < 0) ? -c : c);
      return ma * ma + mb * mb + mc * mc;
    endfunction

    function automatic logic [31:0] scale(longint comp, logic [63:0] p, logic [63:0] len);
      logic [127:0] q;
      logic [127:0] m;
      m = 128'((comp < 0) ? -comp : comp);
      q = (m * {64'd0, p}) / {64'd0, len};
      if (comp >= 0) begin
        if (q > 128'h7fffffff) q = 128'h7fffffff;
        return q[31:0];
      end
      if (q > 128'h80000000) q = 128'h80000000;
      return 32'd0 - q[31:0];
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (hi < v) return hi;
      return v;
    endfunction

    function automatic push_result_t predict_push(overlap_query_t w);
      push_result_t r;
      longint       vx, vy, vz, qx, qy, qz;
      logic [127:0] s, r2;
      logic [63:0]  d, p;
      r = '{hit: 1'b0, px: '0, py: '0, pz: '0};
      vx = longint'(w.cx) - clamp(w.cx, w.lox, w.hix);
      vy = longint'(w.cy) - clamp(w.cy, w.loy, w.hiy);
      vz = longint'(w.cz) - clamp(w.cz, w.loz, w.hiz);
      s = sumsq(vx, vy, vz);
      r2 = {97'd0, w.radius} * {97'd0, w.radius};
      if (r2 <= s) return r;
      n_hits++;
      d = isqrt(s);
      p = {33'd0, w.radius} - d;
      r.hit = 1'b1;
      if (s != 0) begin
        r.px = scale(vx, p, d);
        r.py = scale(vy, p, d);
        r.pz = scale(vz, p, d);
        return r;
      end
      n_inside++;
      qx = 2 * longint'(w.cx) - w.lox - w.hix;
      qy = 2 * longint'(w.cy) - w.loy - w.hiy;
      qz = 2 * longint'(w.cz) - w.loz - w.hiz;
      s = sumsq(qx, qy, qz);
      if (s == 0) begin
        n_midpoint++;
        r.py = p[31:0];
        return r;
      end
      d = isqrt(s);
      r.px = scale(qx, p, d);
      r.py = scale(qy, p, d);
      r.pz = scale(qz, p, d);
      return r;
    endfunction

    function void note_query(overlap_query_t w);
      pending_q.insert(pending_q.size(), predict_push(w));
    endfunction

    function void check_push(push_result_t got);
      push_result_t exp;
      n_checked++;
      if (pending_q.size() == 0) begin
        $error("result word with no expectation pending");
        failures++;
        return;
      end
      exp = pending_q.pop_front();
      if (got.hit !== exp.hit) begin
        $error("hit: expected %0d, got %0d", exp.hit, got.hit);
        failures++;
      end
      if (got.px !== exp.px) begin
        $error("push_x: expected %0d, got %0d", exp.px, got.px);
        failures++;
      end
      if (got.py !== exp.py) begin
        $error("push_y: expected %0d, got %0d", exp.py, got.py);
        failures++;
      end
      if (got.pz !== exp.pz) begin
        $error("push_z: expected %0d, got %0d", exp.pz, got.pz);
        failures++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   n_sent;
  int   cycles = 0;
  bit   quiet;
  push_scoreboard sb = new();

  sap_in_if  in_if ();
  sap_out_if out_if ();

  sphere_aabb_overlap_push i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_push('{hit: out_if.hit, px: out_if.push_x, py: out_if.push_y,
                      pz: out_if.push_z});
  end

  task automatic send_query(overlap_query_t w);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.sphere_x      <= w.cx;
    in_if.sphere_y      <= w.cy;
    in_if.sphere_z      <= w.cz;
    in_if.sphere_radius <= w.radius;
    in_if.box_min_x     <= w.lox;
    in_if.box_min_y     <= w.loy;
    in_if.box_min_z     <= w.loz;
    in_if.box_max_x     <= w.hix;
    in_if.box_max_y     <= w.hiy;
    in_if.box_max_z     <= w.hiz;
    do @(posedge clk); while (!in_if.ready);
    sb.note_query(w);
    n_sent++;
    if (n_sent >= QUIET_FROM) quiet = 1'b1;
  endtask

  function automatic overlap_query_t make_query(int cx, int cy, int cz, int radius,
                                                int lox, int loy, int loz,
                                                int hix, int hiy, int hiz);
    overlap_query_t w;
    w.cx = cx; w.cy = cy; w.cz = cz; w.radius = radius[30:0];
    w.lox = lox; w.loy = loy; w.loz = loz;
    w.hix = hix; w.hiy = hiy; w.hiz = hiz;
    return w;
  endfunction

  function automatic int near_coord();
    return int'($urandom_range(0, 1 << 22)) - (1 << 21);
  endfunction

  function automatic overlap_query_t random_query();
    overlap_query_t w;
    int             mode;
    mode = $urandom_range(0, 9);
    w.lox = near_coord(); w.loy = near_coord(); w.loz = near_coord();
    w.hix = w.lox + int'($urandom_range(0, 1 << 20));
    w.hiy = w.loy + int'($urandom_range(0, 1 << 20));
    w.hiz = w.loz + int'($urandom_range(0, 1 << 20));
    w.radius = 31'($urandom_range(0, 1 << 21));
    w.cx = near_coord(); w.cy = near_coord(); w.cz = near_coord();
    if (mode == 0) begin
      w = make_query($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom);
    end else if (mode <= 2) begin
      w.cx = w.lox + int'($urandom_range(0, w.hix - w.lox));
      w.cy = w.loy + int'($urandom_range(0, w.hiy - w.loy));
      w.cz = w.loz + int'($urandom_range(0, w.hiz - w.loz));
    end else if (mode == 3) begin
      w.hix = w.lox + 2 * int'($urandom_range(0, 1 << 18));
      w.hiy = w.loy + 2 * int'($urandom_range(0, 1 << 18));
      w.hiz = w.loz + 2 * int'($urandom_range(0, 1 << 18));
      w.cx = (w.lox + w.hix) / 2;
      w.cy = (w.loy + w.hiy) / 2;
      w.cz = (w.loz + w.hiz) / 2;
      if ($urandom_range(0, 1)) w.cx = w.cx + 1;
    end else if (mode == 4) begin
      w.hix = w.lox - int'($urandom_range(1, 1 << 16));
    end else begin
      w.cx = w.hix + int'($urandom_range(0, 1 << 19));
      w.cy = w.loy - int'($urandom_range(0, 1 << 19));
    end
    return w;
  endfunction

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.sphere_x = '0; in_if.sphere_y = '0; in_if.sphere_z = '0;
    in_if.sphere_radius = '0;
    in_if.box_min_x = '0; in_if.box_min_y = '0; in_if.box_min_z = '0;
    in_if.box_max_x = '0; in_if.box_max_y = '0; in_if.box_max_z = '0;
    n_sent = 0;
    quiet = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // far away, no hit
    send_query(make_query(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 100,
                          -100, -100, -100, 100, 100, 100));
    send_query(make_query(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff,
                          32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                          32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    // zero radius
    send_query(make_query(0, 0, 0, 0, -10, -10, -10, 10, 10, 10));
    // max radius, one unit outside
    send_query(make_query(32'h7fffffff, 0, 0, 32'h7fffffff, -5, -5, -5, 32'h7ffffffe, 5, 5));
    send_query(make_query(32'h80000000, 0, 0, 32'h7fffffff, 32'h80000001, -5, -5, 5, 5, 5));
    // touching exactly, no hit; then one unit closer, a hit
    send_query(make_query(110, 0, 0, 10, -100, -100, -100, 100, 100, 100));
    send_query(make_query(109, 0, 0, 10, -100, -100, -100, 100, 100, 100));
    // edge region, negative axes
    send_query(make_query(-103, -104, -100, 20, -100, -100, -100, 100, 100, 100));
    // center inside box
    send_query(make_query(30, -20, 5, 1 << 16, -100, -100, -100, 100, 100, 100));
    send_query(make_query(-99, 99, -50, 32'h7fffffff, -100, -100, -100, 100, 100, 100));
    // center at midpoint, pushes up
    send_query(make_query(0, 0, 0, 1 << 16, -100, -100, -100, 100, 100, 100));
    send_query(make_query(32'h7fffffff, 32'h80000000, 0, 32'h7fffffff,
                          32'h7fffffff, 32'h80000000, 0, 32'h7fffffff, 32'h80000000, 0));
    // inverted boxes
    send_query(make_query(0, 0, 0, 50, 10, -10, -10, -10, 10, 10));
    send_query(make_query(20, 0, 0, 50, 10, -10, -10, -10, 10, 10));
    send_query(make_query(5, 0, 0, 50, 10, -10, -10, -10, 10, 10));
    // widest box
    send_query(make_query(1, 2, 3, 7, 32'h80000000, 32'h80000000, 32'h80000000,
                          32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    send_query(make_query(32'h80000000, 32'h7fffffff, 0, 32'h7fffffff,
                          32'h80000000, 32'h80000000, 32'h80000000,
                          32'h7fffffff, 32'h7fffffff, 32'h7fffffff));

    while (n_sent < N_ITEMS) send_query(random_query());
    in_if.valid <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Checked %0d result words: %0d hits, %0d with center inside, %0d at midpoint.",
             sb.n_checked, sb.n_hits, sb.n_inside, sb.n_midpoint);
    $display("Sent %0d query words with random gaps, output stalls and one long hold.",
             n_sent);
    if (sb.failures == 0 && sb.pending_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    int  n;
    bit  held;
    held = 1'b0;
    out_if.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (quiet) begin
        out_if.ready <= 1'b1;
        @(posedge clk);
      end else if (!held && n_sent >= HOLD_AT) begin
        held = 1'b1;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 8);
        out_if.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        n = $urandom_range(1, 16);
        out_if.ready <= 1'b1;
        repeat (n) @(posedge clk);
      end
    end
  end

endmodule
